// ===== sv/text_console_writer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared shorthand for the concurrent checks in the console writer modules.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Command codes, register indexes, reset values and the control and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Command codes of an input word.
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_SET   = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB   = 2'd3;

    // Register reset values.
    localparam logic [7:0] ATTR_RESET = 8'h00;
    localparam logic [7:0] NL_RESET   = 8'd10;
    localparam logic [7:0] BS_RESET   = 8'd8;
    localparam logic [7:0] TAB_RESET  = 8'd9;

    // Cursor step of a tab and the content of a blank cell.
    localparam int unsigned TAB_STEP   = 4;
    localparam logic [15:0] BLANK_CELL = 16'h0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // input word taken this cycle
        logic sweep;       // step the store sweep this cycle
        logic sweep_blank; // sweep writes blanks instead of copying rows up
        logic emit_now;    // result comes straight from the accepted word
        logic emit_sweep;  // result after a finished clear or scroll
        logic emit_read;   // result carries the cell that was read
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scroll; // the offered word pushes the cursor past the last row
        logic is_clear;    // the offered word clears the screen
        logic is_read;     // the offered word reads a cell
        logic sweep_last;  // the sweep is at the last cell of the store
    } t_dp_stat;

endpackage

// ===== sv/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences the reset clearing pass, clear and scroll sweeps, cell reads and
// the timing of the result strobe.
// ----------------------------------------------------------------------------
`include "text_console_writer_core_macros.svh"

module tcw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  tcw_pkg::t_dp_stat i_stat,
    output tcw_pkg::t_ctl_cmd o_cmd
);
    import tcw_pkg::*;

    localparam logic [2:0] ST_INIT       = 3'd0;
    localparam logic [2:0] ST_INIT_FLUSH = 3'd1;
    localparam logic [2:0] ST_IDLE       = 3'd2;
    localparam logic [2:0] ST_CLEAR      = 3'd3;
    localparam logic [2:0] ST_SCROLL     = 3'd4;
    localparam logic [2:0] ST_FLUSH      = 3'd5;
    localparam logic [2:0] ST_READ       = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Commands decoded from the state.
    always_comb begin
        o_cmd.accept      = (r_state == ST_IDLE) && start;
        o_cmd.sweep       = (r_state == ST_INIT) || (r_state == ST_CLEAR) ||
                            (r_state == ST_SCROLL);
        o_cmd.sweep_blank = (r_state == ST_INIT) || (r_state == ST_CLEAR);
        o_cmd.emit_now    = o_cmd.accept && !i_stat.is_clear && !i_stat.need_scroll &&
                            !i_stat.is_read;
        o_cmd.emit_sweep  = (r_state == ST_FLUSH);
        o_cmd.emit_read   = (r_state == ST_READ);
    end

    assign busy = (r_state != ST_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (i_stat.sweep_last) n_state = ST_INIT_FLUSH;
            end
            ST_INIT_FLUSH: n_state = ST_IDLE;
            ST_IDLE: begin
                if (start) begin
                    priority if (i_stat.is_clear)    n_state = ST_CLEAR;
                    else if (i_stat.need_scroll)     n_state = ST_SCROLL;
                    else if (i_stat.is_read)         n_state = ST_READ;
                    else                             n_state = ST_IDLE;
                end
            end
            ST_CLEAR, ST_SCROLL: begin
                if (i_stat.sweep_last) n_state = ST_FLUSH;
            end
            ST_FLUSH: n_state = ST_IDLE;
            ST_READ:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    `TCW_ASSERT_NEXT(a_clear_enters_sweep, i_clk, i_rst_n, o_cmd.accept && i_stat.is_clear, r_state == ST_CLEAR, "clear word did not start a sweep")
    `TCW_ASSERT_NEXT(a_scroll_ends_flush, i_clk, i_rst_n, (r_state == ST_SCROLL) && i_stat.sweep_last, r_state == ST_FLUSH, "scroll sweep did not end in flush")
    `TCW_ASSERT_SAME(a_one_emit, i_clk, i_rst_n, 1'b1, ($onehot0({o_cmd.emit_now, o_cmd.emit_sweep, o_cmd.emit_read})), "two result sources at once")

endmodule

// ===== sv/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// Text console writer datapath
// Holds the cell store, the cursor, the configuration registers, the sweep
// address and the result registers.
// ----------------------------------------------------------------------------
`include "text_console_writer_core_macros.svh"

module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tcw_pkg::t_ctl_cmd                i_cmd,
    output tcw_pkg::t_dp_stat                o_stat,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [7:0]                       i_cfg_data,
    input  logic [1:0]                       i_command,
    input  logic [7:0]                       i_char_code,
    input  logic [6:0]                       i_pos_x,
    input  logic [4:0]                       i_pos_y,
    output logic                             o_result_valid,
    output logic [6:0]                       o_cursor_x,
    output logic [4:0]                       o_cursor_y,
    output logic [7:0]                       o_cell_char,
    output logic [7:0]                       o_cell_attr,
    output logic                             o_scrolled
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);
    localparam int COPY  = CELLS - COLUMNS;

    // Configuration registers.
    logic [7:0] r_attr;
    logic [7:0] r_nl_code;
    logic [7:0] r_bs_code;
    logic [7:0] r_tab_code;

    // Cursor.
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    // Cell store and its ports.
    logic [15:0]   r_mem [CELLS];
    logic [15:0]   r_rd_data;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   mem_wdata;

    // Sweep address and the delayed write stage behind the read.
    logic [AW-1:0] r_sweep_addr;
    logic          r_wd_valid;
    logic [AW-1:0] r_wd_addr;
    logic          r_wd_blank;
    logic          sweep_copy;

    // Item bookkeeping.
    logic r_rd_oor;
    logic r_mode_scroll;

    // Result registers.
    logic       r_out_valid;
    logic [6:0] r_out_x;
    logic [4:0] r_out_y;
    logic [7:0] r_out_char;
    logic [7:0] r_out_attr;
    logic       r_out_scr;

    // Decode of the offered word.
    logic          is_put;
    logic          ch_nl;
    logic          ch_bs;
    logic          ch_tab;
    logic          ch_ord;
    logic          col_last;
    logic          row_last;
    logic          tab_ok;
    logic          rd_in_range;
    logic [AW-1:0] put_addr;
    logic [AW-1:0] cell_addr;
    logic [CW-1:0] set_col;
    logic [RW-1:0] set_row;

    assign is_put   = (i_command == CMD_PUT);
    assign ch_nl    = (i_char_code == r_nl_code);
    assign ch_bs    = !ch_nl && (i_char_code == r_bs_code);
    assign ch_tab   = !ch_nl && !ch_bs && (i_char_code == r_tab_code);
    assign ch_ord   = !ch_nl && !ch_bs && !ch_tab;
    assign col_last = (r_col == CW'(COLUMNS - 1));
    assign row_last = (r_row == RW'(ROWS - 1));
    assign tab_ok   = ((8'(r_col) + 8'(TAB_STEP)) <= 8'(COLUMNS - 1));

    assign rd_in_range = (32'(i_pos_x) < 32'(COLUMNS)) && (32'(i_pos_y) < 32'(ROWS));
    assign put_addr    = AW'(AW'(r_row) * AW'(COLUMNS) + AW'(r_col));
    assign cell_addr   = AW'(AW'(i_pos_y) * AW'(COLUMNS) + AW'(i_pos_x));

    // Set cursor saturates each coordinate at the screen edge.
    assign set_col = (32'(i_pos_x) > 32'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(i_pos_x);
    assign set_row = (32'(i_pos_y) > 32'(ROWS - 1))    ? RW'(ROWS - 1)    : RW'(i_pos_y);

    // Status toward the controller.
    assign o_stat.need_scroll = is_put && row_last && (ch_nl || (ch_ord && col_last));
    assign o_stat.is_clear    = (i_command == CMD_CLEAR);
    assign o_stat.is_read     = (i_command == CMD_READ);
    assign o_stat.sweep_last  = (r_sweep_addr == AW'(CELLS - 1));

    // Cursor after the offered word.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        unique case (i_command)
            CMD_PUT: begin
                priority if (ch_nl) begin
                    n_col = '0;
                    if (!row_last) n_row = r_row + 1'b1;
                end else if (ch_bs) begin
                    if (r_col != '0) n_col = r_col - 1'b1;
                end else if (ch_tab) begin
                    if (tab_ok) n_col = r_col + CW'(TAB_STEP);
                end else begin
                    if (col_last) begin
                        n_col = '0;
                        if (!row_last) n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            CMD_CLEAR: begin
                n_col = '0;
                n_row = '0;
            end
            CMD_SET: begin
                n_col = set_col;
                n_row = set_row;
            end
            CMD_READ: begin
                n_col = r_col;
                n_row = r_row;
            end
            default: begin
                n_col = r_col;
                n_row = r_row;
            end
        endcase
    end

    // Store ports: the delayed sweep write and the character write never meet.
    assign sweep_copy = (r_sweep_addr < AW'(COPY));
    assign mem_we     = r_wd_valid || (i_cmd.accept && is_put && ch_ord);
    assign mem_waddr  = r_wd_valid ? r_wd_addr : put_addr;
    assign mem_wdata  = r_wd_valid ? (r_wd_blank ? BLANK_CELL : r_rd_data)
                                   : {r_attr, i_char_code};
    assign mem_re     = (i_cmd.accept && o_stat.is_read && rd_in_range) ||
                        (i_cmd.sweep && !i_cmd.sweep_blank && sweep_copy);
    assign mem_raddr  = i_cmd.accept ? cell_addr : AW'(r_sweep_addr + AW'(COLUMNS));

    // Cell store with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rd_data <= r_mem[mem_raddr];
    end

    // Configuration writes; the port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr     <= ATTR_RESET;
            r_nl_code  <= NL_RESET;
            r_bs_code  <= BS_RESET;
            r_tab_code <= TAB_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ATTR: r_attr     <= i_cfg_data;
                CFG_NL:   r_nl_code  <= i_cfg_data;
                CFG_BS:   r_bs_code  <= i_cfg_data;
                CFG_TAB:  r_tab_code <= i_cfg_data;
                default:  r_attr     <= r_attr;
            endcase
        end
    end

    // Cursor, sweep address and control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_sweep_addr <= '0;
            r_wd_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_col        <= n_col;
                r_row        <= n_row;
                r_sweep_addr <= '0;
            end else if (i_cmd.sweep) begin
                r_sweep_addr <= r_sweep_addr + 1'b1;
            end
            r_wd_valid  <= i_cmd.sweep;
            r_out_valid <= i_cmd.emit_now || i_cmd.emit_sweep || i_cmd.emit_read;
        end
    end

    // Sweep write stage and item flags.
    always_ff @(posedge i_clk) begin
        r_wd_addr  <= r_sweep_addr;
        r_wd_blank <= i_cmd.sweep_blank || !sweep_copy;
        if (i_cmd.accept) begin
            r_rd_oor      <= !rd_in_range;
            r_mode_scroll <= o_stat.need_scroll;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.emit_now) begin
            r_out_x    <= 7'(n_col);
            r_out_y    <= 5'(n_row);
            r_out_char <= 8'h00;
            r_out_attr <= 8'h00;
            r_out_scr  <= 1'b0;
        end else if (i_cmd.emit_sweep) begin
            r_out_x    <= 7'(r_col);
            r_out_y    <= 5'(r_row);
            r_out_char <= 8'h00;
            r_out_attr <= 8'h00;
            r_out_scr  <= r_mode_scroll;
        end else if (i_cmd.emit_read) begin
            r_out_x    <= 7'(r_col);
            r_out_y    <= 5'(r_row);
            r_out_char <= r_rd_oor ? 8'h00 : r_rd_data[7:0];
            r_out_attr <= r_rd_oor ? 8'h00 : r_rd_data[15:8];
            r_out_scr  <= 1'b0;
        end else begin
            r_out_x    <= r_out_x;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_cursor_x     = r_out_x;
    assign o_cursor_y     = r_out_y;
    assign o_cell_char    = r_out_char;
    assign o_cell_attr    = r_out_attr;
    assign o_scrolled     = r_out_scr;

    `TCW_ASSERT_SAME(a_no_write_clash, i_clk, i_rst_n, i_cmd.accept, !r_wd_valid, "character write met a sweep write")
    `TCW_ASSERT_SAME(a_cursor_bounds, i_clk, i_rst_n, 1'b1, (r_col <= CW'(COLUMNS - 1)) && (r_row <= RW'(ROWS - 1)), "cursor left the screen")

endmodule

// ===== sv/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// Text console writer core
// A character cell console: COLUMNS x ROWS cells of character and attribute
// with a cursor, driven by put character, clear, set cursor and read commands.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; each word gives exactly
// one result, shown for one cycle with o_result_valid, and the receiver
// cannot stall it. Put character without a scroll and set cursor words can
// follow each other every cycle, with the result registered in the next
// cycle. A cell read holds busy while the registered store read completes.
// A clear, or a put character that moves past the last row, sweeps the whole
// store through its single read and write port, one cell a cycle, and holds
// busy until the sweep and its flush state are done. After reset the same
// sweep clears the store and busy stays high throughout, while configuration
// writes are still taken.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_command,
    input  logic [7:0]                    i_char_code,
    input  logic [6:0]                    i_pos_x,
    input  logic [4:0]                    i_pos_y,
    output logic                          o_result_valid,
    output logic [6:0]                    o_cursor_x,
    output logic [4:0]                    o_cursor_y,
    output logic [7:0]                    o_cell_char,
    output logic [7:0]                    o_cell_attr,
    output logic                          o_scrolled,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);
    import tcw_pkg::*;

    t_ctl_cmd ctl_cmd;
    t_dp_stat dp_stat;

    // Sequencing.
    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (ctl_cmd)
    );

    // Store, cursor and result registers.
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (ctl_cmd),
        .o_stat         (dp_stat),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_char_code    (i_char_code),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .o_result_valid (o_result_valid),
        .o_cursor_x     (o_cursor_x),
        .o_cursor_y     (o_cursor_y),
        .o_cell_char    (o_cell_char),
        .o_cell_attr    (o_cell_attr),
        .o_scrolled     (o_scrolled)
    );

endmodule

// ===== tb/sv/text_console_writer_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console writer core testbench
// Drives put character, clear, set cursor and read words into the console,
// mirrors the cell store, cursor and registers in a behavioral copy, and
// checks every result word field by field. A directed table comes first,
// followed by random phases under different register settings.
// ----------------------------------------------------------------------------
module text_console_writer_core_test;
    import tcw_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_WORDS = 80;
    localparam int PHASES      = 6;
    localparam int SHOWN_MAX   = 10;

    // One result word as seen on the output ports.
    typedef struct packed {
        logic [6:0] cursor_x;
        logic [4:0] cursor_y;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic       scrolled;
    } t_console_status;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    // A directed step: a command word or a register write.
    typedef struct packed {
        t_row_kind       kind;
        logic [1:0]      command;
        logic [7:0]      char_code;
        logic [6:0]      pos_x;
        logic [4:0]      pos_y;
        logic [1:0]      reg_index;
        logic            typed;
        t_console_status status;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 32;

    // Typed expectations cover the reset state, the extremes and the
    // out-of-range reads; other rows go through the behavioral copy.
    // Register rows carry the write data in char_code.
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_WORD, CMD_READ,  8'h00, 7'd0,   5'd0,  CFG_ATTR, 1'b1,
          '{7'd0,  5'd0,  8'h00, 8'h00, 1'b0}},
        '{ROW_WORD, CMD_PUT,   8'h41, 7'd0,   5'd0,  CFG_ATTR, 1'b0, '0},
        '{ROW_WORD, CMD_PUT,   8'h08, 7'd0,   5'd0,  CFG_ATTR, 1'b0, '0},
        '{ROW_WORD, CMD_PUT,   8'h08, 7'd0,   5'd0,  CFG_ATTR, 1'b1,
          '{7'd0,  5'd0,  8'h00, 8'h00, 1'b0}},
        '{ROW_WORD, CMD_READ,  8'h00, 7'd0,   5'd0,  CFG_ATTR, 1'b0, '0},
        '{ROW_WORD, CMD_SET,   8'h00, 7'd127, 5'd31, CFG_ATTR, 1'b1,
          '{7'd79, 5'd24, 8'h00, 8'h00, 1'b0}},
        '{ROW_WORD, CMD_PUT,   8'h09, 7'd0,   5'd0,  CFG_ATTR, 1'b1,
          '{7'd79, 5'd24, 8'h00, 8'h00, 1'b0}},
        '{ROW_WORD, CMD_SET,   8'h00, 7'd75,  5'd3,  CFG_ATTR, 1'b0, '0},
        '{ROW_WORD, CMD_PUT,   8'h09, 7'd0,   5'd0,  CFG_ATTR, 1'b0, '0},
        '{ROW_REG,  CMD_PUT,   8'hFF, 7'd0,   5'd0,  CFG_ATTR, 1'b0, '0},
        '{ROW_WORD, CMD_PUT,   8'hFF, 7'd0,   5'd0,  CFG_ATTR, 1'b0, '0},
        '{ROW_WORD, CMD_PUT,   8'h00, 7'd0,   5'd0,  CFG_ATTR, 1'b0, '0},
        '{ROW_WORD, CMD_READ,  8'h00, 7'd79,  5'd3,  CFG_ATTR, 1'b0, '0},
        '{ROW_WORD, CMD_SET,   8'h00, 7'd79,  5'd24, CFG_ATTR, 1'b0, '0},
        '{ROW_WORD, CMD_PUT,   8'h7E, 7'd0,   5'd0,  CFG_ATTR, 1'b1,
          '{7'd0,  5'd24, 8'h00, 8'h00, 1'b1}},
        '{ROW_WORD, CMD_READ,  8'h00, 7'd79,  5'd23, CFG_ATTR, 1'b0, '0},
        '{ROW_WORD, CMD_READ,  8'h00, 7'd80,  5'd0,  CFG_ATTR, 1'b1,
          '{7'd0,  5'd24, 8'h00, 8'h00, 1'b0}},
        '{ROW_WORD, CMD_READ,  8'h00, 7'd0,   5'd25, CFG_ATTR, 1'b1,
          '{7'd0,  5'd24, 8'h00, 8'h00, 1'b0}},
        '{ROW_WORD, CMD_READ,  8'h00, 7'd127, 5'd31, CFG_ATTR, 1'b1,
          '{7'd0,  5'd24, 8'h00, 8'h00, 1'b0}},
        '{ROW_WORD, CMD_PUT,   8'h0A, 7'd0,   5'd0,  CFG_ATTR, 1'b1,
          '{7'd0,  5'd24, 8'h00, 8'h00, 1'b1}},
        '{ROW_REG,  CMD_PUT,   8'h20, 7'd0,   5'd0,  CFG_NL,   1'b0, '0},
        '{ROW_REG,  CMD_PUT,   8'h20, 7'd0,   5'd0,  CFG_BS,   1'b0, '0},
        '{ROW_REG,  CMD_PUT,   8'h20, 7'd0,   5'd0,  CFG_TAB,  1'b0, '0},
        '{ROW_WORD, CMD_SET,   8'h00, 7'd5,   5'd2,  CFG_ATTR, 1'b0, '0},
        '{ROW_WORD, CMD_PUT,   8'h20, 7'd0,   5'd0,  CFG_ATTR, 1'b0, '0},
        '{ROW_REG,  CMD_PUT,   8'h00, 7'd0,   5'd0,  CFG_NL,   1'b0, '0},
        '{ROW_WORD, CMD_PUT,   8'h20, 7'd0,   5'd0,  CFG_ATTR, 1'b0, '0},
        '{ROW_WORD, CMD_SET,   8'h00, 7'd5,   5'd2,  CFG_ATTR, 1'b0, '0},
        '{ROW_WORD, CMD_PUT,   8'h20, 7'd0,   5'd0,  CFG_ATTR, 1'b0, '0},
        '{ROW_WORD, CMD_PUT,   8'h00, 7'd0,   5'd0,  CFG_ATTR, 1'b0, '0},
        '{ROW_WORD, CMD_CLEAR, 8'h00, 7'd0,   5'd0,  CFG_ATTR, 1'b1,
          '{7'd0,  5'd0,  8'h00, 8'h00, 1'b0}},
        '{ROW_WORD, CMD_READ,  8'h00, 7'd79,  5'd3,  CFG_ATTR, 1'b1,
          '{7'd0,  5'd0,  8'h00, 8'h00, 1'b0}}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           i_command;
    logic [7:0]           i_char_code;
    logic [6:0]           i_pos_x;
    logic [4:0]           i_pos_y;
    logic                 o_result_valid;
    logic [6:0]           o_cursor_x;
    logic [4:0]           o_cursor_y;
    logic [7:0]           o_cell_char;
    logic [7:0]           o_cell_attr;
    logic                 o_scrolled;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    // Behavioral copy of the console state and registers.
    logic [15:0] screen_model [COLUMNS*ROWS];
    logic [6:0]  cursor_col_model;
    logic [4:0]  cursor_row_model;
    logic [7:0]  attr_model;
    logic [7:0]  newline_model;
    logic [7:0]  backspace_model;
    logic [7:0]  tab_model;

    t_console_status status_expected [$];
    int              fail_count   = 0;
    int              shown_count  = 0;
    int              stall_cycles = 0;
    bit              idle_enabled = 1'b1;

    text_console_writer_core #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_char_code   (i_char_code),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .o_result_valid(o_result_valid),
        .o_cursor_x    (o_cursor_x),
        .o_cursor_y    (o_cursor_y),
        .o_cell_char   (o_cell_char),
        .o_cell_attr   (o_cell_attr),
        .o_scrolled    (o_scrolled),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Move the cursor one row down, scrolling the store at the bottom.
    task automatic step_row_down(output logic rolled);
        int i;
        rolled = 1'b0;
        if (int'(cursor_row_model) == ROWS - 1) begin
            for (i = 0; i < COLUMNS * (ROWS - 1); i++) begin
                screen_model[i] = screen_model[i + COLUMNS];
            end
            for (i = COLUMNS * (ROWS - 1); i < COLUMNS * ROWS; i++) begin
                screen_model[i] = BLANK_CELL;
            end
            rolled = 1'b1;
        end else begin
            cursor_row_model = cursor_row_model + 5'd1;
        end
    endtask

    // Apply one accepted word to the copy and work out its result.
    task automatic apply_console_word(input logic [1:0] cmd, input logic [7:0] ch,
                                      input logic [6:0] px, input logic [4:0] py,
                                      output t_console_status status);
        logic rolled;
        int   i;
        rolled = 1'b0;
        status = '0;
        case (cmd)
            CMD_PUT: begin
                // Newline wins over backspace, backspace over tab.
                if (ch == newline_model) begin
                    cursor_col_model = 7'd0;
                    step_row_down(rolled);
                end else if (ch == backspace_model) begin
                    if (cursor_col_model != 7'd0) begin
                        cursor_col_model = cursor_col_model - 7'd1;
                    end
                end else if (ch == tab_model) begin
                    if (int'(cursor_col_model) + int'(TAB_STEP) <= COLUMNS - 1) begin
                        cursor_col_model = cursor_col_model + 7'(TAB_STEP);
                    end
                end else begin
                    i = int'(cursor_row_model) * COLUMNS + int'(cursor_col_model);
                    screen_model[i] = {attr_model, ch};
                    if (int'(cursor_col_model) == COLUMNS - 1) begin
                        cursor_col_model = 7'd0;
                        step_row_down(rolled);
                    end else begin
                        cursor_col_model = cursor_col_model + 7'd1;
                    end
                end
            end
            CMD_CLEAR: begin
                for (i = 0; i < COLUMNS * ROWS; i++) begin
                    screen_model[i] = BLANK_CELL;
                end
                cursor_col_model = 7'd0;
                cursor_row_model = 5'd0;
            end
            CMD_SET: begin
                // Coordinates saturate at the last column and row.
                cursor_col_model = (int'(px) > COLUMNS - 1) ? 7'(COLUMNS - 1) : px;
                cursor_row_model = (int'(py) > ROWS - 1) ? 5'(ROWS - 1) : py;
            end
            default: begin
                // A read outside the screen returns a blank cell.
                if (int'(px) < COLUMNS && int'(py) < ROWS) begin
                    i = int'(py) * COLUMNS + int'(px);
                    status.cell_char = screen_model[i][7:0];
                    status.cell_attr = screen_model[i][15:8];
                end
            end
        endcase
        status.cursor_x = cursor_col_model;
        status.cursor_y = cursor_row_model;
        status.scrolled = rolled;
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic wait_results_drained();
        start <= 1'b0;
        while (status_expected.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write one register while the console is idle. The valid is lowered
    // by the next command word or at the end of the run.
    task automatic write_register(input logic [1:0] idx, input logic [7:0] data);
        wait_results_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1));
        case (idx)
            CFG_ATTR: attr_model      = data;
            CFG_NL:   newline_model   = data;
            CFG_BS:   backspace_model = data;
            default:  tab_model       = data;
        endcase
    endtask

    // Offer one command word after a random gap and record its expectation.
    task automatic issue_word(input logic [1:0] cmd, input logic [7:0] ch,
                              input logic [6:0] px, input logic [4:0] py,
                              input logic typed, input t_console_status typed_status);
        t_console_status predicted;
        i_cfg_valid <= 1'b0;
        while (idle_enabled && $urandom_range(0, 99) < 25) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_command   <= cmd;
        i_char_code <= ch;
        i_pos_x     <= px;
        i_pos_y     <= py;
        do @(posedge i_clk); while (!(start === 1'b1 && busy === 1'b0));
        apply_console_word(cmd, ch, px, py, predicted);
        status_expected.push_back(typed ? typed_status : predicted);
    endtask

    // Compare each result word with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_console_status want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (status_expected.size() == 0) begin
                fail_count++;
                if (shown_count < SHOWN_MAX) begin
                    shown_count++;
                    $display("unexpected result word: x=%0d y=%0d char=%h attr=%h scr=%b",
                             o_cursor_x, o_cursor_y, o_cell_char, o_cell_attr, o_scrolled);
                end
            end else begin
                want = status_expected.pop_front();
                if (o_cursor_x !== want.cursor_x || o_cursor_y !== want.cursor_y ||
                    o_cell_char !== want.cell_char || o_cell_attr !== want.cell_attr ||
                    o_scrolled !== want.scrolled) begin
                    fail_count++;
                    if (shown_count < SHOWN_MAX) begin
                        shown_count++;
                        $display("mismatch: expected x=%0d y=%0d char=%h attr=%h scr=%b",
                                 want.cursor_x, want.cursor_y, want.cell_char,
                                 want.cell_attr, want.scrolled);
                        $display("          actual   x=%0d y=%0d char=%h attr=%h scr=%b",
                                 o_cursor_x, o_cursor_y, o_cell_char, o_cell_attr,
                                 o_scrolled);
                    end
                end
            end
        end
    end

    // End the run when nothing has moved for too long.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_result_valid === 1'b1 ||
            (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int              row;
        int              phase;
        int              n;
        int              pick;
        int              spread;
        logic [1:0]      cmd;
        logic [7:0]      ch;
        logic [6:0]      px;
        logic [4:0]      py;
        logic [7:0]      shared_code;
        t_directed_row   entry;

        // Every input starts at a known value.
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_command   <= CMD_PUT;
        i_char_code <= 8'h00;
        i_pos_x     <= 7'd0;
        i_pos_y     <= 5'd0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_ATTR;
        i_cfg_data  <= 8'h00;

        for (n = 0; n < COLUMNS * ROWS; n++) begin
            screen_model[n] = BLANK_CELL;
        end
        cursor_col_model = 7'd0;
        cursor_row_model = 5'd0;
        attr_model       = ATTR_RESET;
        newline_model    = NL_RESET;
        backspace_model  = BS_RESET;
        tab_model        = TAB_RESET;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            entry = directed_rows[row];
            if (entry.kind == ROW_REG) begin
                write_register(entry.reg_index, entry.char_code);
            end else begin
                issue_word(entry.command, entry.char_code, entry.pos_x, entry.pos_y,
                           entry.typed, entry.status);
            end
        end

        // Random phases, each under its own register setting.
        for (phase = 0; phase < PHASES; phase++) begin
            shared_code = 8'($urandom_range(0, 255));
            case (phase)
                0: begin
                    write_register(CFG_ATTR, 8'($urandom_range(0, 255)));
                    write_register(CFG_NL, NL_RESET);
                    write_register(CFG_BS, BS_RESET);
                    write_register(CFG_TAB, TAB_RESET);
                end
                1: begin
                    write_register(CFG_ATTR, 8'hFF);
                    write_register(CFG_NL, 8'hFF);
                    write_register(CFG_BS, 8'h00);
                    write_register(CFG_TAB, 8'h80);
                end
                2: begin
                    write_register(CFG_ATTR, 8'h00);
                    write_register(CFG_NL, 8'h7F);
                    write_register(CFG_BS, 8'h01);
                    write_register(CFG_TAB, 8'hFE);
                end
                3: begin
                    write_register(CFG_ATTR, 8'($urandom_range(0, 255)));
                    write_register(CFG_NL, shared_code);
                    write_register(CFG_BS, shared_code);
                    write_register(CFG_TAB, 8'($urandom_range(0, 255)));
                end
                4: begin
                    write_register(CFG_ATTR, 8'($urandom_range(0, 255)));
                    write_register(CFG_NL, 8'($urandom_range(0, 255)));
                    write_register(CFG_BS, shared_code);
                    write_register(CFG_TAB, shared_code);
                end
                default: begin
                    write_register(CFG_ATTR, 8'($urandom_range(0, 255)));
                    write_register(CFG_NL, 8'($urandom_range(0, 255)));
                    write_register(CFG_BS, 8'($urandom_range(0, 255)));
                    write_register(CFG_TAB, 8'($urandom_range(0, 255)));
                end
            endcase

            // One phase offers its words with no random gaps between them.
            idle_enabled = (phase != 1);

            for (n = 0; n < PHASE_WORDS; n++) begin
                if (status_expected.size() != 0 && $urandom_range(0, 39) == 0) begin
                    wait_results_drained();
                end
                ch   = 8'($urandom_range(0, 255));
                px   = 7'($urandom_range(0, 127));
                py   = 5'($urandom_range(0, 31));
                pick = $urandom_range(0, 99);
                if (pick < 2) begin
                    cmd = CMD_CLEAR;
                end else if (pick < 16) begin
                    // Cursor moves lean toward the bottom rows to provoke scrolls.
                    cmd    = CMD_SET;
                    spread = $urandom_range(0, 99);
                    if ($urandom_range(0, 99) < 80) px = 7'($urandom_range(0, COLUMNS - 1));
                    if (spread < 30) begin
                        py = 5'($urandom_range(ROWS - 5, ROWS - 1));
                    end else if (spread < 90) begin
                        py = 5'($urandom_range(0, ROWS - 1));
                    end
                end else if (pick < 34) begin
                    cmd = CMD_READ;
                    if ($urandom_range(0, 99) < 85) begin
                        px = 7'($urandom_range(0, COLUMNS - 1));
                        py = 5'($urandom_range(0, ROWS - 1));
                    end
                end else begin
                    cmd    = CMD_PUT;
                    spread = $urandom_range(0, 99);
                    if (spread < 12) begin
                        ch = newline_model;
                    end else if (spread < 22) begin
                        ch = backspace_model;
                    end else if (spread < 32) begin
                        ch = tab_model;
                    end
                end
                issue_word(cmd, ch, px, py, 1'b0, '0);
            end
        end

        // Let the last results come back, then a short tail.
        wait_results_drained();
        i_cfg_valid <= 1'b0;
        repeat (4) @(posedge i_clk);
        if (status_expected.size() != 0) begin
            fail_count++;
            $display("%0d result words never arrived", status_expected.size());
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_ctrl.sv
sv/tcw_datapath.sv
sv/text_console_writer_core.sv
tb/sv/text_console_writer_core_test.sv
